/* sv/negacyclic_poly_mul_mod_q_assert.svh */
// -----------------------------------------------------------------------------
// Negacyclic multiplier assertion macros
// Shared property wrappers for the checks at the end of the top level.
// -----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH
`define NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define NMQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define NMQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/nmq_pkg.sv */
// -----------------------------------------------------------------------------
// nmq_pkg
// Constants, codes and controller/datapath interface types of the
// negacyclic polynomial multiplier mod Q.
// -----------------------------------------------------------------------------
package nmq_pkg;

	// Ring and field sizes
	localparam int DEGREE     = 256;
	localparam int IDX_W      = 8;
	localparam int COEFF_IN_W = 31;
	localparam int COEFF_W    = 30;
	localparam logic [COEFF_W-1:0] MOD_Q = 30'd1073643521;

	// Exact accumulation: DEGREE products of two COEFF_W values, plus sign
	localparam int PROD_W    = 2 * COEFF_W;
	localparam int ACC_W     = PROD_W + IDX_W + 1;

	// Reduction by folding: 2^30 = 2^16 + 2^15 - 1 (mod Q).
	// Five folds bring any |acc| below 2^30.
	localparam int FOLD_SH_HI = 16;
	localparam int FOLD_SH_LO = 15;
	localparam int RED_STEPS  = 5;
	localparam int RED_CNT_W  = $clog2(RED_STEPS);
	localparam int CNT_W      = (IDX_W > RED_CNT_W) ? IDX_W : RED_CNT_W;

	// Transaction kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_REDUCE,
		ST_FIN
	} nmq_state_t;

	// Controller to datapath
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             mac_en;
		logic [IDX_W-1:0] mac_idx;
		logic             red_load;
		logic             red_step;
		logic             out_load;
	} nmq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} nmq_sts_t;

endpackage

/* sv/nmq_dp.sv */
// -----------------------------------------------------------------------------
// nmq_dp
// Datapath: operand stores, multiply-accumulate pipeline, folding
// reduction mod Q and the output register.
// -----------------------------------------------------------------------------
module nmq_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  nmq_pkg::nmq_cmd_t                     cmd,
	input  logic [nmq_pkg::IDX_W-1:0]             index,
	input  logic signed [nmq_pkg::COEFF_IN_W-1:0] coeff_first,
	input  logic signed [nmq_pkg::COEFF_IN_W-1:0] coeff_second,
	input  logic                                  out_ready,
	output nmq_pkg::nmq_sts_t                     sts,
	output logic                                  out_valid,
	output logic [nmq_pkg::COEFF_W-1:0]           product_coeff,
	output logic [nmq_pkg::IDX_W-1:0]             product_index
);
	import nmq_pkg::*;

	// Bring a signed input coefficient into 0..Q-1 (|x| < 2Q)
	function automatic logic [COEFF_W-1:0] reduce_in(input logic signed [COEFF_IN_W-1:0] x);
		logic signed [COEFF_IN_W+1:0] xe;
		logic signed [COEFF_IN_W+1:0] qe;
		logic signed [COEFF_IN_W+1:0] t;
		xe = {{2{x[COEFF_IN_W-1]}}, x};
		qe = {{(COEFF_IN_W+2-COEFF_W){1'b0}}, MOD_Q};
		if (xe < 0) begin
			t = xe + qe;
			if (t < 0) begin
				t = t + qe;
			end
		end else if (xe >= qe) begin
			t = xe - qe;
		end else begin
			t = xe;
		end
		return t[COEFF_W-1:0];
	endfunction

	logic [COEFF_W-1:0] mem_a [DEGREE];
	logic [COEFF_W-1:0] mem_b [DEGREE];

	logic [IDX_W-1:0]         k_q;
	logic [COEFF_W-1:0]       a_s1;
	logic [COEFF_W-1:0]       b_s1;
	logic                     vld_s1;
	logic                     wrap_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic                     vld_s2;
	logic                     wrap_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]         mag_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic [COEFF_W-1:0]       product_coeff_q;
	logic [IDX_W-1:0]         product_index_q;

	logic                     wrap_c;
	logic [IDX_W:0]           j_sum_c;
	logic [IDX_W-1:0]         j_c;
	logic signed [ACC_W-1:0]  term_c;
	logic [ACC_W-1:0]         fold_hi_c;
	logic [ACC_W-1:0]         fold_c;
	logic [COEFF_W-1:0]       rem_c;
	logic [COEFF_W-1:0]       result_c;

	// Partner index: j = k - i, or k + DEGREE - i for wrapped terms
	always_comb begin
		wrap_c  = cmd.mac_idx > k_q;
		j_sum_c = {1'b0, k_q} - {1'b0, cmd.mac_idx}
			+ (wrap_c ? (IDX_W+1)'(DEGREE) : '0);
		j_c     = j_sum_c[IDX_W-1:0];
	end

	// Operand stores, registered reads
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_a[index] <= reduce_in(coeff_first);
			mem_b[index] <= reduce_in(coeff_second);
		end
		if (cmd.mac_en) begin
			a_s1 <= mem_a[cmd.mac_idx];
			b_s1 <= mem_b[j_c];
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mac_en;
			vld_s2 <= vld_s1;
		end
	end

	// Term sign, product, position
	always_ff @(posedge clk) begin
		wrap_s1 <= wrap_c;
		wrap_s2 <= wrap_s1;
		prod_s2 <= a_s1 * b_s1;
		if (cmd.start) begin
			k_q <= index;
		end
	end

	// Exact signed accumulation of the products
	always_comb begin
		term_c = {{(ACC_W-PROD_W){1'b0}}, prod_s2};
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= wrap_s2 ? acc_q - term_c : acc_q + term_c;
		end
	end

	// Fold the bits above 2^30 back in, then one compare and subtract
	always_comb begin
		fold_hi_c = {{COEFF_W{1'b0}}, mag_q[ACC_W-1:COEFF_W]};
		fold_c    = (fold_hi_c << FOLD_SH_HI) + (fold_hi_c << FOLD_SH_LO) - fold_hi_c
			+ {{(ACC_W-COEFF_W){1'b0}}, mag_q[COEFF_W-1:0]};
		rem_c     = (mag_q[COEFF_W-1:0] >= MOD_Q) ? mag_q[COEFF_W-1:0] - MOD_Q
			: mag_q[COEFF_W-1:0];
		result_c  = (neg_q && (rem_c != '0)) ? MOD_Q - rem_c : rem_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.red_load) begin
			mag_q <= acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
			neg_q <= acc_q[ACC_W-1];
		end else if (cmd.red_step) begin
			mag_q <= fold_c;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			product_coeff_q <= result_c;
			product_index_q <= k_q;
		end
	end

	assign sts.pipe_busy  = vld_s1 | vld_s2;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign product_coeff  = product_coeff_q;
	assign product_index  = product_index_q;

endmodule

/* sv/nmq_ctrl.sv */
// -----------------------------------------------------------------------------
// nmq_ctrl
// Controller: input handshake, term counter and the sequence of
// accumulate, drain, reduce and output steps for a read.
// -----------------------------------------------------------------------------
module nmq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      kind,
	input  logic [nmq_pkg::IDX_W-1:0] index,
	input  nmq_pkg::nmq_sts_t         sts,
	output logic                      in_ready,
	output nmq_pkg::nmq_cmd_t         cmd
);
	import nmq_pkg::*;

	nmq_state_t       state_q;
	nmq_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             accept_c;
	logic             idx_ok_c;
	logic             mac_last_c;
	logic             red_last_c;

	always_comb begin
		accept_c   = in_valid && in_ready;
		idx_ok_c   = {1'b0, index} < (IDX_W+1)'(DEGREE);
		mac_last_c = cnt_q == CNT_W'(DEGREE - 1);
		red_last_c = cnt_q == CNT_W'(RED_STEPS - 1);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_c && (kind == KIND_READ) && idx_ok_c) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (mac_last_c) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_last_c) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = state_q == ST_IDLE;
		cmd.wr_en    = accept_c && (kind == KIND_LOAD) && idx_ok_c;
		cmd.start    = accept_c && (kind == KIND_READ) && idx_ok_c;
		cmd.mac_en   = state_q == ST_MAC;
		cmd.mac_idx  = cnt_q[IDX_W-1:0];
		cmd.red_load = (state_q == ST_DRAIN) && !sts.pipe_busy;
		cmd.red_step = state_q == ST_REDUCE;
		cmd.out_load = (state_q == ST_FIN) && sts.out_free;
	end

	// State and term/step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start || cmd.red_load || (cmd.mac_en && mac_last_c)) begin
				cnt_q <= '0;
			end else if (cmd.mac_en || cmd.red_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

/* sv/negacyclic_poly_mul_mod_q.sv */
// -----------------------------------------------------------------------------
// negacyclic_poly_mul_mod_q
// Schoolbook multiplier in Z_Q[x]/(x^N+1), Q = 1073643521, N = 256.
// Load transactions store one coefficient pair; read transactions return one
// product coefficient reduced into 0..Q-1.
//
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | kind, index, coeff_first, coeff_second
// out     | output    | out_valid/out_ready | product_coeff, product_index
//
// A load is stored when it is accepted. A read runs from accept to the result in
// the output register in order: N terms through the single multiply-accumulate
// unit, a drain of its pipeline, RED_STEPS (5) folds for the reduction mod Q,
// and the load of the output register.
// in_ready is high only while idle; a held result does not block new loads,
// but a read's last cycle waits until an earlier held result is taken.
// Reset (arst_n, asynchronous) clears control only; the stores are undefined.
// -----------------------------------------------------------------------------
`include "negacyclic_poly_mul_mod_q_assert.svh"

module negacyclic_poly_mul_mod_q (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  kind,
	input  logic [nmq_pkg::IDX_W-1:0]             index,
	input  logic signed [nmq_pkg::COEFF_IN_W-1:0] coeff_first,
	input  logic signed [nmq_pkg::COEFF_IN_W-1:0] coeff_second,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [nmq_pkg::COEFF_W-1:0]           product_coeff,
	output logic [nmq_pkg::IDX_W-1:0]             product_index
);
	import nmq_pkg::*;

	nmq_cmd_t cmd;
	nmq_sts_t sts;

	nmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.index    (index),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	nmq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.index         (index),
		.coeff_first   (coeff_first),
		.coeff_second  (coeff_second),
		.out_ready     (out_ready),
		.sts           (sts),
		.out_valid     (out_valid),
		.product_coeff (product_coeff),
		.product_index (product_index)
	);

	// Checks
	`NMQ_ASSERT_NOW(a_cmd_exclusive, 1'b1,
		$onehot0({cmd.wr_en, cmd.start, cmd.mac_en, cmd.red_load, cmd.red_step, cmd.out_load}),
		"controller commands overlap")
	`NMQ_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid && !out_ready),
		"pending result overwritten")
	`NMQ_ASSERT_NEXT(a_start_mac, cmd.start, cmd.mac_en && (cmd.mac_idx == '0),
		"read did not start accumulation at term zero")
	`NMQ_ASSERT_NOW(a_busy_no_accept, cmd.mac_en || cmd.red_step, !in_ready,
		"input accepted during a read")

endmodule
